// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the charlieplex PWM scanner.
// No dependencies; each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/cpwm_pkg.sv
// Package for the charlieplex PWM scanner: sizes, reset values and opcodes.
// No dependencies.
package cpwm_pkg;

  localparam int RAMP_STEPS = 32;
  localparam int PIN_COUNT  = 3;
  localparam int LED_COUNT  = PIN_COUNT * (PIN_COUNT - 1);
  localparam int RAMP_W     = $clog2(RAMP_STEPS);
  localparam int ROW_W      = 2;
  localparam int LEVEL_W    = 8;
  localparam int INDEX_W    = 3;

  localparam logic [RAMP_W-1:0] RAMP_LAST = RAMP_W'(RAMP_STEPS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(PIN_COUNT - 1);

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  // Brightness pair of one row: LEDs 2*row and 2*row+1.
  typedef struct packed {
    logic [LEVEL_W-1:0] second;
    logic [LEVEL_W-1:0] first;
  } row_levels_t;

endpackage

// File: src/charlieplex_pwm_scanner_top.sv
// Charlieplex PWM scanner: an accepted tick transaction gives its result
// transaction in the next cycle; one transaction is accepted every
// cycle while the result register is empty or being drained.
// Write transactions update the brightness store and give no result.
// Reset (rst, synchronous, active high) clears the store and puts the ramp at
// its last step and the row at the last row, so the first tick starts row 0.
`include "assert_macros.svh"

module charlieplex_pwm_scanner_top import cpwm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 opcode,
  input  logic [INDEX_W-1:0]   led_index,
  input  logic [LEVEL_W-1:0]   level,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [PIN_COUNT-1:0] pin_drive_mask,
  output logic [PIN_COUNT-1:0] pin_high_mask
);

  // Brightness store, kept as three rows so the scanner reads one row at a
  // time through a single row select.
  row_levels_t           store [PIN_COUNT];
  logic [RAMP_W-1:0]     ramp_count;
  logic [ROW_W-1:0]      active_row;
  logic [LEVEL_W-1:0]    first_led_level;
  logic [LEVEL_W-1:0]    second_led_level;
  logic [1:0]            column_enable;

  logic [RAMP_W-1:0]     ramp_count_next;
  logic [ROW_W-1:0]      active_row_next;
  logic [LEVEL_W-1:0]    first_led_level_next;
  logic [LEVEL_W-1:0]    second_led_level_next;
  logic [1:0]            column_enable_next;
  logic                  wrap;
  logic [PIN_COUNT-1:0]  row_bit;
  logic [PIN_COUNT-1:0]  row_below;
  logic [PIN_COUNT-1:0]  cols_wide;
  logic [PIN_COUNT-1:0]  cols;
  logic [PIN_COUNT-1:0]  drive;
  logic [PIN_COUNT-1:0]  high;
  logic                  item_accept;
  logic                  is_tick;
  logic                  is_write;

  // The result register frees up when it is empty or taken this cycle, so a
  // new transaction can follow every cycle.
  assign item_ready  = !result_valid || result_ready;
  assign item_accept = item_valid && item_ready;
  assign is_tick     = item_accept && (opcode == OP_TICK);
  assign is_write    = item_accept && (opcode == OP_WRITE);

  // Ramp and row advance. When the ramp wraps, the next row's two levels are
  // latched and both columns come back on, except one whose level is zero.
  always_comb begin
    wrap                  = (ramp_count == RAMP_LAST);
    ramp_count_next       = wrap ? '0 : ramp_count + RAMP_W'(1);
    active_row_next       = active_row;
    first_led_level_next  = first_led_level;
    second_led_level_next = second_led_level;
    column_enable_next    = column_enable;
    if (wrap) begin
      active_row_next       = (active_row == ROW_LAST) ? '0 : active_row + ROW_W'(1);
      first_led_level_next  = store[active_row_next].first;
      second_led_level_next = store[active_row_next].second;
      column_enable_next    = 2'b11;
    end
    // A column goes dark on the step that matches its level; a level at or
    // beyond the ramp length never matches and stays lit all row long.
    if (LEVEL_W'(ramp_count_next) == first_led_level_next) begin
      column_enable_next[0] = 1'b0;
    end
    if (LEVEL_W'(ramp_count_next) == second_led_level_next) begin
      column_enable_next[1] = 1'b0;
    end
  end

  // Map the two columns onto the pins around the row pin: column bits below
  // the row pin keep their place, the rest move up by one.
  always_comb begin
    row_bit   = PIN_COUNT'(1) << active_row_next;
    row_below = row_bit - PIN_COUNT'(1);
    cols_wide = PIN_COUNT'(column_enable_next);
    cols      = (cols_wide & row_below) | ((cols_wide & ~row_below) << 1);
    drive     = (cols != '0) ? (cols | row_bit) : '0;
    high      = (drive != '0) ? row_bit : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < PIN_COUNT; r++) begin
        store[r] <= '0;
      end
      ramp_count       <= RAMP_LAST;
      active_row       <= ROW_LAST;
      first_led_level  <= '0;
      second_led_level <= '0;
      column_enable    <= '0;
    end else begin
      if (is_write && (led_index < INDEX_W'(LED_COUNT))) begin
        if (led_index[0]) begin
          store[led_index[INDEX_W-1:1]].second <= level;
        end else begin
          store[led_index[INDEX_W-1:1]].first <= level;
        end
      end
      if (is_tick) begin
        ramp_count       <= ramp_count_next;
        active_row       <= active_row_next;
        first_led_level  <= first_led_level_next;
        second_led_level <= second_led_level_next;
        column_enable    <= column_enable_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (is_tick) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      pin_drive_mask <= drive;
      pin_high_mask  <= high;
    end
  end

  // Whenever pins are driven, exactly one of them is driven high.
  `ASSERT_IMPLIES(a_one_high_pin, result_valid && |pin_drive_mask, $onehot(pin_high_mask))
  // A pin is only ever driven high if it is driven at all.
  `ASSERT_IMPLIES(a_high_driven, result_valid, (pin_high_mask & ~pin_drive_mask) == '0)
  // Floating pins carry no level.
  `ASSERT_IMPLIES(a_float_low, result_valid && (pin_drive_mask == '0), pin_high_mask == '0)
  // A write into an empty result register makes no result.
  `ASSERT_NEXT(a_write_silent, is_write && !result_valid, !result_valid)
  // Every accepted tick leaves a result waiting.
  `ASSERT_NEXT(a_tick_result, is_tick, result_valid)

endmodule
